// ===== rtl/ring_buffer_indexed_list_assert.svh =====
// Assertion helpers for the ring list; aclk and aresetn must be in scope.
`ifndef RING_BUFFER_INDEXED_LIST_ASSERT_SVH
`define RING_BUFFER_INDEXED_LIST_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define RBIL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RBIL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rbil_pkg.sv =====
package rbil_pkg;

    localparam int RING_SLOTS = 16;
    localparam int VALUE_BITS = 32;
    localparam int SLOT_BITS  = $clog2(RING_SLOTS);

    typedef logic [SLOT_BITS-1:0]  slot_t;
    typedef logic [VALUE_BITS-1:0] value_t;

    localparam slot_t HOME_SLOT = slot_t'((RING_SLOTS - 1) / 2);
    localparam slot_t MAX_LEN   = slot_t'(RING_SLOTS - 1);

    localparam logic [1:0] MODE_READ   = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;
    localparam logic [1:0] MODE_FIND   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  position;
        logic [31:0] item_value;
    } in_t;

    typedef struct packed {
        logic [31:0] read_value;
        logic [3:0]  found_index;
        logic [3:0]  list_length;
        logic [1:0]  status;
    } out_t;

    typedef struct packed {
        logic   we;
        slot_t  waddr;
        value_t wdata;
        logic   re;
        slot_t  raddr;
    } ram_req_t;

endpackage

// ===== rtl/rbil_ram.sv =====
module rbil_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/rbil_ctrl.sv =====
`include "ring_buffer_indexed_list_assert.svh"

module rbil_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  rbil_pkg::in_t     in_data,
    output logic              res_valid,
    input  logic              res_ready,
    output rbil_pkg::out_t    res_data,
    output rbil_pkg::ram_req_t ram_req,
    input  rbil_pkg::value_t  ram_rdata
);
    import rbil_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PLAN  = 3'd1;
    localparam logic [2:0] S_RDATA = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_PUT   = 3'd4;
    localparam logic [2:0] S_FIND  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [1:0] mode_reg, mode_next;
    slot_t      pos_reg, pos_next;
    value_t     val_reg, val_next;
    slot_t      head_reg, head_next;
    slot_t      tail_reg, tail_next;
    slot_t      cur_reg, cur_next;
    slot_t      stop_reg, stop_next;
    logic       up_reg, up_next;
    logic       wpend_reg, wpend_next;
    slot_t      waddr_reg, waddr_next;
    logic       hit_pend_reg, hit_pend_next;
    slot_t      hit_idx_reg, hit_idx_next;
    value_t     rd_reg, rd_next;
    slot_t      found_reg, found_next;
    logic [1:0] status_reg, status_next;

    slot_t len;
    slot_t half;
    slot_t real_slot;
    slot_t step_slot;
    logic  match;

    assign len       = tail_reg - head_reg;
    assign half      = len >> 1;
    assign real_slot = head_reg + pos_reg;
    assign step_slot = up_reg ? cur_reg + slot_t'(1) : cur_reg - slot_t'(1);
    assign match     = (ram_rdata == val_reg);

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    always_comb begin
        res_data.read_value  = 32'(rd_reg);
        res_data.found_index = 4'(found_reg);
        res_data.list_length = 4'(len);
        res_data.status      = status_reg;
    end

    always_comb begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        pos_next      = pos_reg;
        val_next      = val_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        cur_next      = cur_reg;
        stop_next     = stop_reg;
        up_next       = up_reg;
        wpend_next    = 1'b0;
        waddr_next    = waddr_reg;
        hit_pend_next = hit_pend_reg;
        hit_idx_next  = hit_idx_reg;
        rd_next       = rd_reg;
        found_next    = found_reg;
        status_next   = status_reg;

        // pending move lands in the cycle after its read
        ram_req.we    = wpend_reg;
        ram_req.waddr = waddr_reg;
        ram_req.wdata = ram_rdata;
        ram_req.re    = 1'b0;
        ram_req.raddr = step_slot;

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    mode_next   = in_data.mode;
                    pos_next    = slot_t'(in_data.position);
                    val_next    = value_t'(in_data.item_value);
                    rd_next     = '0;
                    found_next  = '0;
                    status_next = ST_OK;
                    state_next  = S_PLAN;
                end
            end
            S_PLAN: begin
                case (mode_reg)
                    MODE_READ: begin
                        if (pos_reg >= len) begin
                            status_next = ST_RANGE;
                            state_next  = S_DONE;
                        end else begin
                            ram_req.re    = 1'b1;
                            ram_req.raddr = real_slot;
                            state_next    = S_RDATA;
                        end
                    end
                    MODE_INSERT: begin
                        if (pos_reg > len) begin
                            status_next = ST_RANGE;
                            state_next  = S_DONE;
                        end else if (len >= MAX_LEN) begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end else if (pos_reg > half) begin
                            // open a gap by pushing the tail side up
                            cur_next   = tail_reg;
                            up_next    = 1'b0;
                            stop_next  = real_slot;
                            tail_next  = tail_reg + slot_t'(1);
                            state_next = S_SHIFT;
                        end else begin
                            cur_next   = head_reg - slot_t'(1);
                            up_next    = 1'b1;
                            stop_next  = real_slot - slot_t'(1);
                            head_next  = head_reg - slot_t'(1);
                            state_next = S_SHIFT;
                        end
                    end
                    MODE_REMOVE: begin
                        if (pos_reg >= len) begin
                            status_next = ST_RANGE;
                            state_next  = S_DONE;
                        end else begin
                            ram_req.re    = 1'b1;
                            ram_req.raddr = real_slot;
                            cur_next      = real_slot;
                            if (pos_reg > half) begin
                                up_next   = 1'b1;
                                stop_next = tail_reg - slot_t'(1);
                                tail_next = tail_reg - slot_t'(1);
                            end else begin
                                up_next   = 1'b0;
                                stop_next = head_reg;
                                head_next = head_reg + slot_t'(1);
                            end
                            state_next = S_RDATA;
                        end
                    end
                    default: begin
                        cur_next      = '0;
                        hit_pend_next = 1'b0;
                        state_next    = S_FIND;
                    end
                endcase
            end
            S_RDATA: begin
                rd_next = ram_rdata;
                if (mode_reg == MODE_REMOVE) begin
                    state_next = S_SHIFT;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_SHIFT: begin
                if (cur_reg != stop_reg) begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = step_slot;
                    wpend_next    = 1'b1;
                    waddr_next    = cur_reg;
                    cur_next      = step_slot;
                end else if (mode_reg == MODE_INSERT) begin
                    state_next = S_PUT;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_PUT: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = stop_reg;
                ram_req.wdata = val_reg;
                state_next    = S_DONE;
            end
            S_FIND: begin
                if (hit_pend_reg && match) begin
                    found_next = hit_idx_reg;
                    state_next = S_DONE;
                end else if (cur_reg == len) begin
                    // drain the last compare before reporting absence
                    hit_pend_next = 1'b0;
                    if (!hit_pend_reg) begin
                        found_next = len;
                        state_next = S_DONE;
                    end
                end else begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = head_reg + cur_reg;
                    hit_pend_next = 1'b1;
                    hit_idx_next  = cur_reg;
                    cur_next      = cur_reg + slot_t'(1);
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            head_reg     <= HOME_SLOT;
            tail_reg     <= HOME_SLOT;
            wpend_reg    <= 1'b0;
            hit_pend_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            wpend_reg    <= wpend_next;
            hit_pend_reg <= hit_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg    <= mode_next;
        pos_reg     <= pos_next;
        val_reg     <= val_next;
        cur_reg     <= cur_next;
        stop_reg    <= stop_next;
        up_reg      <= up_next;
        waddr_reg   <= waddr_next;
        hit_idx_reg <= hit_idx_next;
        rd_reg      <= rd_next;
        found_reg   <= found_next;
        status_reg  <= status_next;
    end

    `RBIL_ASSERT_NOW(a_rw_apart, ram_req.we && ram_req.re, ram_req.waddr != ram_req.raddr, "move writes the slot being read")
    `RBIL_ASSERT_NOW(a_idle_drained, state_reg == S_IDLE, !wpend_reg, "move still pending in idle")
    `RBIL_ASSERT_NOW(a_full_insert, res_valid && status_reg == ST_FULL, mode_reg == MODE_INSERT, "full flag on a non-insert")
    `RBIL_ASSERT_NEXT(a_one_beat, in_valid && in_ready, !in_ready, "second beat taken while busy")
    `RBIL_ASSERT_NEXT(a_find_keeps, state_reg == S_FIND, $stable(head_reg) && $stable(tail_reg), "find moved the ring pointers")

endmodule

// ===== rtl/ring_buffer_indexed_list.sv =====
// Ordered list of up to 15 values held in a 16-slot ring.
// Input channel s_valid/s_ready/s_data carries one request beat: mode
// (read, insert, remove, find), position and item_value. Result channel
// m_valid/m_ready/m_data returns exactly one beat per request with the
// value read or removed, the found index, the new length and a status.
// One request is worked at a time; s_ready is low from acceptance until
// the result is handed to the output register.
// A flagged request goes from planning straight to the result; a read
// fetches its entry first; insert and remove move entries (at most half
// the length) and find compares up to length entries.
// The single slot memory port pair allows one entry moved or compared
// per cycle. A new request is accepted the cycle after the previous result
// leaves the sequencer, even while that result still waits in the output
// register.
// A stalled receiver holds m_data steady; the next result then waits in
// the sequencer and s_ready stays low.
// Reset empties the list (head and tail at slot 7); slot contents are not
// cleared and are never read before being written.
module ring_buffer_indexed_list (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  rbil_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output rbil_pkg::out_t m_data
);
    import rbil_pkg::*;

    ram_req_t ram_req;
    value_t   ram_rdata;
    logic     res_valid;
    logic     res_ready;
    out_t     res_data;

    logic     m_valid_reg, m_valid_next;
    out_t     m_data_reg, m_data_next;

    rbil_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    rbil_ram #(
        .DEPTH (RING_SLOTS),
        .WIDTH (VALUE_BITS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    // output register frees the sequencer once the beat is parked
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_data_next  = res_data;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== dv/tb_ring_buffer_indexed_list.sv =====
module tb_ring_buffer_indexed_list;
    timeunit 1ns;
    timeprecision 1ps;

    import rbil_pkg::*;

    localparam int STALL_LIMIT     = 4000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_ITEMS    = 410;

    logic   aclk    = 1'b0;
    logic   aresetn = 1'b0;
    logic   s_valid = 1'b0;
    logic   s_ready;
    in_t    s_data  = '0;
    logic   m_valid;
    logic   m_ready = 1'b0;
    out_t   m_data;

    // shadow of the list: slot contents plus head and one-past-tail pointers
    value_t list_slots [RING_SLOTS];
    slot_t  first_slot;
    slot_t  end_slot;

    out_t   pending_results [$];
    int     mismatch_count = 0;
    int     send_idle_pct  = 0;
    int     recv_stall_pct = 0;
    int     hold_request   = 0;
    int     hold_left      = 0;
    int     quiet_cycles   = 0;
    bit     filling        = 1'b1;

    ring_buffer_indexed_list dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    function automatic slot_t current_length();
        return slot_t'(end_slot - first_slot);
    endfunction

    // Apply one request to the shadow list and return the result it should produce.
    function automatic out_t apply_list_op(in_t req);
        out_t  res;
        slot_t len;
        slot_t pos;
        slot_t target;
        slot_t i;
        res = '0;
        len = current_length();
        pos = req.position;
        case (req.mode)
            MODE_READ: begin
                if (pos >= len)
                    res.status = ST_RANGE;
                else
                    res.read_value = list_slots[slot_t'(first_slot + pos)];
            end
            MODE_INSERT: begin
                if (pos > len) begin
                    res.status = ST_RANGE;
                end else if (len >= MAX_LEN) begin
                    res.status = ST_FULL;
                end else if (pos > (len >> 1)) begin
                    // open a gap by shifting the tail side up one slot
                    target = slot_t'(first_slot + pos);
                    i = end_slot;
                    while (i != target) begin
                        list_slots[i] = list_slots[slot_t'(i - 1)];
                        i = slot_t'(i - 1);
                    end
                    list_slots[target] = req.item_value;
                    end_slot = slot_t'(end_slot + 1);
                end else begin
                    // grow at the head and shift the head side down one slot
                    first_slot = slot_t'(first_slot - 1);
                    target = slot_t'(first_slot + pos);
                    i = first_slot;
                    while (i != target) begin
                        list_slots[i] = list_slots[slot_t'(i + 1)];
                        i = slot_t'(i + 1);
                    end
                    list_slots[target] = req.item_value;
                end
            end
            MODE_REMOVE: begin
                if (pos >= len) begin
                    res.status = ST_RANGE;
                end else begin
                    target = slot_t'(first_slot + pos);
                    res.read_value = list_slots[target];
                    i = target;
                    if (pos > (len >> 1)) begin
                        while (slot_t'(i + 1) != end_slot) begin
                            list_slots[i] = list_slots[slot_t'(i + 1)];
                            i = slot_t'(i + 1);
                        end
                        end_slot = slot_t'(end_slot - 1);
                    end else begin
                        while (i != first_slot) begin
                            list_slots[i] = list_slots[slot_t'(i - 1)];
                            i = slot_t'(i - 1);
                        end
                        first_slot = slot_t'(first_slot + 1);
                    end
                end
            end
            default: begin
                i = '0;
                while (i != len && list_slots[slot_t'(first_slot + i)] != req.item_value)
                    i = slot_t'(i + 1);
                res.found_index = i;
            end
        endcase
        res.list_length = current_length();
        return res;
    endfunction

    function automatic in_t make_request(logic [1:0] mode, int pos, value_t val);
        in_t req;
        req.mode       = mode;
        req.position   = pos[3:0];
        req.item_value = val;
        return req;
    endfunction

    // Mostly well-formed requests; bias toward filling or draining so both ends get hit.
    function automatic in_t random_request();
        in_t req;
        int  len;
        int  pick;
        len = int'(current_length());
        if (len >= 14)
            filling = 1'b0;
        else if (len <= 1)
            filling = 1'b1;
        pick = $urandom_range(99);
        if (pick < (filling ? 50 : 15))
            req.mode = MODE_INSERT;
        else if (pick < 65)
            req.mode = MODE_REMOVE;
        else if (pick < 83)
            req.mode = MODE_READ;
        else
            req.mode = MODE_FIND;

        if ($urandom_range(99) < 12)
            req.position = 4'($urandom_range(15));
        else if (req.mode == MODE_INSERT)
            req.position = 4'($urandom_range(len));
        else if (len > 0)
            req.position = 4'($urandom_range(len - 1));
        else
            req.position = 4'($urandom_range(15));

        case ($urandom_range(9))
            0:       req.item_value = '0;
            1:       req.item_value = '1;
            2, 3:    req.item_value = value_t'($urandom_range(3));
            default: req.item_value = $urandom;
        endcase
        // search for a value that is really there most of the time
        if (req.mode == MODE_FIND && len > 0 && $urandom_range(99) < 60)
            req.item_value = list_slots[slot_t'(first_slot + $urandom_range(len - 1))];
        return req;
    endfunction

    task automatic set_idling(int send_pct, int stall_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
    endtask

    task automatic send_request(in_t req);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(apply_list_op(req));
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic test_empty_list();
        set_idling(0, 0);
        send_request(make_request(MODE_READ, 0, 32'h0));
        send_request(make_request(MODE_REMOVE, 0, 32'h0));
        send_request(make_request(MODE_INSERT, 1, 32'hDEAD_BEEF));
        send_request(make_request(MODE_FIND, 0, 32'h0));
    endtask

    task automatic test_fill_to_full();
        send_request(make_request(MODE_INSERT, 0, 32'h0000_0000));
        send_request(make_request(MODE_INSERT, 1, 32'hFFFF_FFFF));
        for (int k = 0; k < 13; k++)
            send_request(make_request(MODE_INSERT, (k * 7) % (k + 3), 32'h1000_0000 + k));
        // full list: inserts drop, index checked first
        send_request(make_request(MODE_INSERT, 7, 32'h5555_5555));
        send_request(make_request(MODE_INSERT, 15, 32'hAAAA_AAAA));
        send_request(make_request(MODE_READ, 15, 32'h0));
        send_request(make_request(MODE_READ, 14, 32'h0));
        send_request(make_request(MODE_FIND, 0, 32'hFFFF_FFFF));
        send_request(make_request(MODE_FIND, 0, 32'h1234_5678));
        send_request(make_request(MODE_REMOVE, 13, 32'h0));
        send_request(make_request(MODE_REMOVE, 0, 32'h0));
        send_request(make_request(MODE_REMOVE, 6, 32'h0));
        send_request(make_request(MODE_REMOVE, 7, 32'h0));
        wait_for_drain();
    endtask

    task automatic test_random_traffic(int send_pct, int stall_pct, int count);
        set_idling(send_pct, stall_pct);
        repeat (count)
            send_request(random_request());
    endtask

    // Hold the result channel so the block backs up, then pause until it drains.
    task automatic test_output_backpressure();
        set_idling(0, 0);
        hold_request = HOLD_OFF_CYCLES;
        repeat (12)
            send_request(random_request());
        wait_for_drain();
        repeat (20)
            send_request(random_request());
        wait_for_drain();
    endtask

    always @(posedge aclk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no request outstanding: %h", m_data);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_data.read_value !== want.read_value) begin
                    $error("read_value expected %h got %h", want.read_value, m_data.read_value);
                    mismatch_count++;
                end
                if (m_data.found_index !== want.found_index) begin
                    $error("found_index expected %0d got %0d",
                           want.found_index, m_data.found_index);
                    mismatch_count++;
                end
                if (m_data.list_length !== want.list_length) begin
                    $error("list_length expected %0d got %0d",
                           want.list_length, m_data.list_length);
                    mismatch_count++;
                end
                if (m_data.status !== want.status) begin
                    $error("status expected %0d got %0d", want.status, m_data.status);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_ring_buffer_indexed_list failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        for (int k = 0; k < RING_SLOTS; k++)
            list_slots[k] = '0;
        first_slot = HOME_SLOT;
        end_slot   = HOME_SLOT;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_list();
        test_fill_to_full();
        test_random_traffic(0, 0, RANDOM_ITEMS);
        test_random_traffic(60, 0, RANDOM_ITEMS);
        test_output_backpressure();
        test_random_traffic(0, 60, RANDOM_ITEMS);
        test_random_traffic(17, 17, RANDOM_ITEMS);

        wait_for_drain();
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0)
            $display("tb_ring_buffer_indexed_list passed");
        else
            $display("tb_ring_buffer_indexed_list failed");
        $finish;
    end

endmodule
